// ===== rtl/dti_pkg.sv =====
// Shared types and constants for the four-letter trie insert/lookup block
`timescale 1ns / 1ps

package dti_pkg;

   // alphabet bytes and their slot numbers in a node row
   localparam logic [7:0] LETTER_A = 8'h61;
   localparam logic [7:0] LETTER_C = 8'h63;
   localparam logic [7:0] LETTER_T = 8'h74;
   localparam logic [7:0] LETTER_G = 8'h67;

   localparam int         LETTERS  = 4;
   localparam logic [1:0] SLOT_A   = 2'd0;
   localparam logic [1:0] SLOT_C   = 2'd1;
   localparam logic [1:0] SLOT_T   = 2'd2;
   localparam logic [1:0] SLOT_G   = 2'd3;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // register file layout
   localparam int         CSR_ADDR_W      = 3;
   localparam int         CSR_DATA_W      = 32;
   localparam int         MAX_NODES_W     = 9;
   localparam logic       REG_MAX_NODES   = 1'b0;
   localparam logic [8:0] MAX_NODES_RESET = 9'd256;

   // input transaction
   typedef struct packed {
      logic       req_type;
      logic [7:0] symbol;
      logic       word_end;
   } req_type_type;

   // result transaction
   typedef struct packed {
      logic       word_found;
      logic       table_full;
      logic [7:0] end_node;
   } rsp_type;

   // decoded character
   typedef struct packed {
      logic       hit;
      logic [1:0] slot;
   } letter_type;

   function automatic letter_type letter_code(input logic [7:0] symbol);
      letter_type lc;
      lc.hit  = 1'b1;
      lc.slot = SLOT_A;
      case (symbol)
         LETTER_A: lc.slot = SLOT_A;
         LETTER_C: lc.slot = SLOT_C;
         LETTER_T: lc.slot = SLOT_T;
         LETTER_G: lc.slot = SLOT_G;
         default:  lc.hit  = 1'b0;
      endcase
      return lc;
   endfunction

endpackage

// ===== rtl/dti_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port
`timescale 1ns / 1ps

module dti_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dti_csr.sv =====
// APB-style register file holding the node limit
`timescale 1ns / 1ps

module dti_csr
   import dti_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready,
   output logic [MAX_NODES_W-1:0] max_nodes
);

   logic [MAX_NODES_W-1:0] max_nodes_ff;
   logic [MAX_NODES_W-1:0] max_nodes_in;
   logic                   reg_hit;
   logic                   wr_strobe;

   // word index decode
   assign reg_hit   = paddr[CSR_ADDR_W-1] == REG_MAX_NODES;
   assign wr_strobe = psel && penable && pwrite && pready;

   // register update
   always_comb begin
      max_nodes_in = max_nodes_ff;
      if (wr_strobe && reg_hit) begin
         max_nodes_in = pwdata[MAX_NODES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_nodes_ff <= MAX_NODES_RESET;
      end else begin
         max_nodes_ff <= max_nodes_in;
      end
   end

   // read back
   assign prdata    = reg_hit ? CSR_DATA_W'(max_nodes_ff) : '0;
   assign pready    = 1'b1;
   assign max_nodes = max_nodes_ff;

endmodule

// ===== rtl/dna_trie_insert_lookup.sv =====
// Top level of the four-letter trie: walk sequencer around the node-row memory
`timescale 1ns / 1ps

// Trie over the letters a, c, t, g, fed one byte per request transaction.
// req_data carries req_type (insert / lookup), symbol and word_end; other
// bytes than the four letters are skipped. A byte with word_end set yields
// one rsp transaction (word_found, table_full, end_node); other bytes none.
// The APB port holds max_nodes, the node budget including the root.
// Each node is one memory row: four child pointers plus its final mark.
// The row of the current node is read at accept and acted on in the
// execute step. An extra step follows when a new node is made (the new
// row is cleared in an extra write) or when a word ends on an existing
// edge (the row of the target is read for its final mark).
// The word-end result is registered. Input stays stalled while a byte is
// at work; a further byte is taken while a result waits, and the block
// holds a new result until rsp_stall drops. After reset a clearing pass
// writes the root row before the first byte is taken; max_nodes returns
// to 256.
module dna_trie_insert_lookup
   import dti_pkg::*;
#(
   parameter int NODES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NW  = $clog2(NODES);
   localparam int NFW = NW + 1;
   localparam int CW  = (NFW > MAX_NODES_W) ? NFW : MAX_NODES_W;
   localparam int RW  = LETTERS * NW + 1;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;

   typedef struct packed {
      logic                          mark;
      logic [LETTERS-1:0][NW-1:0]    next_node;
   } row_type;

   logic [2:0]             state_ff, state_in;
   logic [NW-1:0]          walk_node_ff, walk_node_in;
   logic                   walk_failed_ff, walk_failed_in;
   logic [NFW-1:0]         next_free_ff, next_free_in;
   logic                   new_mark_ff, new_mark_in;
   req_type_type           item_ff, item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [MAX_NODES_W-1:0] max_nodes;
   logic                   ram_wr_en;
   logic [NW-1:0]          ram_wr_addr;
   row_type                ram_wr_row;
   logic                   ram_rd_en;
   logic [NW-1:0]          ram_rd_addr;
   logic [RW-1:0]          ram_rd_data;

   row_type                row;
   letter_type             lc;
   logic                   is_lookup;
   logic                   step;
   logic [NW-1:0]          target;
   logic                   room;
   logic                   hit_edge;
   logic                   alloc;
   logic                   fail_now;
   logic                   out_free;
   logic                   req_accept;

   // register file
   dti_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .max_nodes (max_nodes)
   );

   // node rows: child pointers and final mark
   dti_ram #(
      .WIDTH (RW),
      .DEPTH (NODES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_row),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // decode of the byte under work against the row just read
   assign row        = row_type'(ram_rd_data);
   assign lc         = letter_code(item_ff.symbol);
   assign is_lookup  = item_ff.req_type == REQ_LOOKUP;
   assign step       = lc.hit && !walk_failed_ff;
   assign target     = row.next_node[lc.slot];
   assign room       = (CW'(next_free_ff) < CW'(max_nodes)) &&
                       (CW'(next_free_ff) < CW'(NODES));
   assign hit_edge   = step && (target != '0);
   assign alloc      = step && (target == '0) && !is_lookup && room;
   assign fail_now   = step && (target == '0) && !alloc;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   // walk sequencer
   always_comb begin
      state_in       = state_ff;
      walk_node_in   = walk_node_ff;
      walk_failed_in = walk_failed_ff;
      next_free_in   = next_free_ff;
      new_mark_in    = new_mark_ff;
      item_in        = item_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = walk_node_ff;
      ram_wr_row     = row;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = walk_node_ff;

      case (state_ff)
         // clear the root row after reset
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_row  = '0;
            state_in    = ST_IDLE;
         end

         // take a byte and fetch the current node row
         ST_IDLE: begin
            if (req_accept) begin
               item_in   = req_data;
               ram_rd_en = 1'b1;
               state_in  = ST_EXEC;
            end
         end

         // follow, create or miss the edge, or end the word on the current node
         ST_EXEC: begin
            if (alloc) begin
               ram_wr_en                      = 1'b1;
               ram_wr_row.next_node[lc.slot]  = next_free_ff[NW-1:0];
               walk_node_in                   = next_free_ff[NW-1:0];
               next_free_in                   = next_free_ff + NFW'(1);
               new_mark_in                    = item_ff.word_end;
               state_in                       = ST_CLEAR;
            end else if (hit_edge) begin
               walk_node_in = target;
               if (item_ff.word_end) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = target;
                  state_in    = ST_END;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!item_ff.word_end) begin
               walk_failed_in = walk_failed_ff || fail_now;
               state_in       = ST_IDLE;
            end else if (out_free) begin
               // word ends on the node whose row is in hand
               rsp_valid_in = 1'b1;
               if (walk_failed_ff || fail_now) begin
                  rsp_data_in.word_found = 1'b0;
                  rsp_data_in.table_full = !is_lookup;
                  rsp_data_in.end_node   = '0;
               end else begin
                  rsp_data_in.word_found = is_lookup && row.mark;
                  rsp_data_in.table_full = 1'b0;
                  rsp_data_in.end_node   = 8'(walk_node_ff);
                  if (!is_lookup) begin
                     ram_wr_en       = 1'b1;
                     ram_wr_row.mark = 1'b1;
                  end
               end
               walk_node_in   = '0;
               walk_failed_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end

         // clear the row of the new node, marked when the word ends here
         ST_CLEAR: begin
            if (!new_mark_ff) begin
               ram_wr_en  = 1'b1;
               ram_wr_row = '0;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               ram_wr_en              = 1'b1;
               ram_wr_row             = '0;
               ram_wr_row.mark        = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_data_in.word_found = 1'b0;
               rsp_data_in.table_full = 1'b0;
               rsp_data_in.end_node   = 8'(walk_node_ff);
               walk_node_in           = '0;
               walk_failed_in         = 1'b0;
               state_in               = ST_IDLE;
            end
         end

         // word ended on an existing edge: target row in hand
         ST_END: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.word_found = is_lookup && row.mark;
               rsp_data_in.table_full = 1'b0;
               rsp_data_in.end_node   = 8'(walk_node_ff);
               if (!is_lookup) begin
                  ram_wr_en       = 1'b1;
                  ram_wr_row.mark = 1'b1;
               end
               walk_node_in   = '0;
               walk_failed_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         walk_node_ff   <= '0;
         walk_failed_ff <= 1'b0;
         next_free_ff   <= NFW'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walk_node_ff   <= walk_node_in;
         walk_failed_ff <= walk_failed_in;
         next_free_ff   <= next_free_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      new_mark_ff <= new_mark_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NFW'(NODES))
      else $error("node allocator ran past the table");

   a_walk_allocated: assert property (@(posedge clock) disable iff (reset)
      {1'b0, walk_node_ff} < next_free_ff)
      else $error("walk reached a node that was never allocated");

   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && ram_wr_en))
      else $error("row write in the cycle a byte is accepted");

   a_exec_follows_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted byte not taken into the execute step");
`endif

endmodule
